// ----- src/psgf_pkg.sv -----
// ----------------------------------------------------------------------------
// psgf_pkg
// Shared constants, types and arithmetic helpers for the path sort, gap
// filter and smoothing core.
// ----------------------------------------------------------------------------
package psgf_pkg;

  // Point capacity of one path load.
  localparam int PTS   = 64;
  localparam int IDX_W = $clog2(PTS);
  localparam int CNT_W = IDX_W + 1;

  // Coordinate width and the width of one stored point (x, y, z).
  localparam int CRD_W = 32;
  localparam int PT_W  = 3 * CRD_W;
  localparam int THR_W = 16;

  localparam logic [THR_W-1:0] GAP_RESET = 16'd200;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    ST_LOAD    = 10'b00_0000_0001,
    ST_KEY_RD  = 10'b00_0000_0010,
    ST_KEY_CAP = 10'b00_0000_0100,
    ST_CMP_RD  = 10'b00_0000_1000,
    ST_CMP     = 10'b00_0001_0000,
    ST_ORD_WR  = 10'b00_0010_0000,
    ST_FLT_RD  = 10'b00_0100_0000,
    ST_FLT_PT  = 10'b00_1000_0000,
    ST_FLT_EV  = 10'b01_0000_0000,
    ST_FIN     = 10'b10_0000_0000
  } psgf_state_t;

  // Magnitude of a signed coordinate as an unsigned value.
  function automatic logic [CRD_W-1:0] mag(input logic [CRD_W-1:0] v);
    mag = v[CRD_W-1] ? (~v + 1'b1) : v;
  endfunction

  // 1:2:1 weighted sum, arithmetic shift right by two, low 32 bits kept.
  function automatic logic [CRD_W-1:0] smooth(input logic [CRD_W-1:0] a,
                                               input logic [CRD_W-1:0] b,
                                               input logic [CRD_W-1:0] c);
    logic [CRD_W+1:0] s;
    s = {{2{a[CRD_W-1]}}, a} + {b[CRD_W-1], b, 1'b0} + {{2{c[CRD_W-1]}}, c};
    smooth = s[CRD_W+1:2];
  endfunction

endpackage

// ----- src/psgf_ram.sv -----
// ----------------------------------------------------------------------------
// psgf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when read enable is high.
// ----------------------------------------------------------------------------
module psgf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/path_sort_gap_filter_smooth_core.sv -----
// ----------------------------------------------------------------------------
// path_sort_gap_filter_smooth_core
// Loads path points, sorts them by |y| through a rank pass over the point
// memory, filters by y gap and streams 1:2:1 smoothed interior points.
// ----------------------------------------------------------------------------
// Load: one point transaction per cycle; no result for non-final points.
// After the final point, ranking runs (one point memory read port shared by
// key fetch and compare sweep), then the filter pass takes each sorted point
// through order read, point read and evaluate states, plus output stalls.
// The filter pass finishes one sorted point before it reads the next.
// Reset (synchronous, rst_n low): empty load, no overflow, threshold 200.
// ----------------------------------------------------------------------------
module path_sort_gap_filter_smooth_core
  import psgf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [THR_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [CRD_W-1:0] in_x_coord,
  input  logic signed [CRD_W-1:0] in_y_coord,
  input  logic signed [CRD_W-1:0] in_z_coord,
  input  logic                    in_final_point,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [CRD_W-1:0] out_x,
  output logic signed [CRD_W-1:0] out_y,
  output logic signed [CRD_W-1:0] out_z,
  output logic                    out_empty_result,
  output logic                    out_overflowed,
  output logic                    out_end_of_run
);

  psgf_state_t      state_r, state_nxt;
  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, n_r, n_nxt;
  logic             ovf_r, ovf_nxt, run_ovf_r, run_ovf_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [IDX_W-1:0] rank_r, rank_nxt;
  logic [CRD_W-1:0] key_r, key_nxt, prev_r, prev_nxt;
  logic [1:0]       kcnt_r, kcnt_nxt;
  logic [PT_W-1:0]  k0_r, k0_nxt, k1_r, k1_nxt, pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;

  // Output register.
  logic             oval_r, oval_nxt;
  logic [PT_W-1:0]  opt_r, opt_nxt;
  logic             oemp_r, oemp_nxt, oovf_r, oovf_nxt, oeor_r, oeor_nxt;

  // Memory ports.
  logic             pt_we, pt_re, ord_we, ord_re;
  logic [IDX_W-1:0] pt_waddr, pt_raddr, ord_waddr, ord_raddr;
  logic [PT_W-1:0]  pt_wdata, pt_rdata;
  logic [IDX_W-1:0] ord_wdata, ord_rdata;

  // Working values.
  logic             in_acc, out_free, room;
  logic [CRD_W-1:0] rd_y, mj;
  logic [CRD_W+1:0] dy, ady;
  logic             keep;
  logic [PT_W-1:0]  sm;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !oval_r || out_ready;
  assign room      = (cnt_r < CNT_W'(PTS));
  assign rd_y      = pt_rdata[2*CRD_W-1:CRD_W];
  assign mj        = mag(rd_y);

  // Gap test against the previous sorted point, computed in 34 bits.
  assign dy  = {{2{rd_y[CRD_W-1]}}, rd_y} - {{2{prev_r[CRD_W-1]}}, prev_r};
  assign ady = dy[CRD_W+1] ? (~dy + 1'b1) : dy;
  assign keep = (i_r != '0) && ((i_r + 1'b1) < n_r) &&
                (ady > {{(CRD_W+2-THR_W){1'b0}}, thr_r});

  // Smoothed point from the last two kept points and the current one.
  assign sm = {smooth(k0_r[3*CRD_W-1:2*CRD_W], k1_r[3*CRD_W-1:2*CRD_W],
                      pt_rdata[3*CRD_W-1:2*CRD_W]),
               smooth(k0_r[2*CRD_W-1:CRD_W], k1_r[2*CRD_W-1:CRD_W],
                      pt_rdata[2*CRD_W-1:CRD_W]),
               smooth(k0_r[CRD_W-1:0], k1_r[CRD_W-1:0], pt_rdata[CRD_W-1:0])};

  // Point memory: written in arrival order during the load.
  assign pt_we    = in_acc && room;
  assign pt_waddr = cnt_r[IDX_W-1:0];
  assign pt_wdata = {in_x_coord, in_y_coord, in_z_coord};

  // Sorted order memory: sorted position to arrival index.
  assign ord_we    = (state_r == ST_ORD_WR);
  assign ord_waddr = rank_r;
  assign ord_wdata = i_r[IDX_W-1:0];
  assign ord_re    = (state_r == ST_FLT_RD);
  assign ord_raddr = i_r[IDX_W-1:0];

  // Point memory read address selection.
  always_comb begin
    pt_re    = 1'b0;
    pt_raddr = i_r[IDX_W-1:0];
    unique case (state_r)
      ST_KEY_RD: begin
        pt_re    = 1'b1;
        pt_raddr = i_r[IDX_W-1:0];
      end
      ST_CMP_RD: begin
        pt_re    = 1'b1;
        pt_raddr = j_r[IDX_W-1:0];
      end
      ST_FLT_PT: begin
        pt_re    = 1'b1;
        pt_raddr = ord_rdata;
      end
      default: begin
        pt_re = 1'b0;
      end
    endcase
  end

  psgf_ram #(.WIDTH(PT_W), .DEPTH(PTS)) u_pt_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  psgf_ram #(.WIDTH(IDX_W), .DEPTH(PTS)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .re    (ord_re),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Sequencer: load, rank sort, gap filter and smoothing.
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    ovf_nxt     = ovf_r;
    run_ovf_nxt = run_ovf_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    rank_nxt    = rank_r;
    key_nxt     = key_r;
    prev_nxt    = prev_r;
    kcnt_nxt    = kcnt_r;
    k0_nxt      = k0_r;
    k1_nxt      = k1_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    oval_nxt    = oval_r && !out_ready;
    opt_nxt     = opt_r;
    oemp_nxt    = oemp_r;
    oovf_nxt    = oovf_r;
    oeor_nxt    = oeor_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_point) begin
            n_nxt       = room ? (cnt_r + 1'b1) : cnt_r;
            run_ovf_nxt = ovf_r || !room;
            cnt_nxt     = '0;
            ovf_nxt     = 1'b0;
            i_nxt       = '0;
            state_nxt   = ST_KEY_RD;
          end
        end
      end
      ST_KEY_RD: begin
        state_nxt = ST_KEY_CAP;
      end
      ST_KEY_CAP: begin
        key_nxt   = mj;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = ST_CMP_RD;
      end
      ST_CMP_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // Earlier arrivals win ties, which keeps the sort stable.
        if ((mj < key_r) || ((mj == key_r) && (j_r < i_r))) begin
          rank_nxt = rank_r + 1'b1;
        end
        if ((j_r + 1'b1) == n_r) begin
          state_nxt = ST_ORD_WR;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_CMP_RD;
        end
      end
      ST_ORD_WR: begin
        if ((i_r + 1'b1) == n_r) begin
          i_nxt      = '0;
          kcnt_nxt   = '0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_FLT_RD;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_KEY_RD;
        end
      end
      ST_FLT_RD: begin
        state_nxt = ST_FLT_PT;
      end
      ST_FLT_PT: begin
        state_nxt = ST_FLT_EV;
      end
      ST_FLT_EV: begin
        // A new smoothed point pushes the pending one out; hold if blocked.
        if (!(keep && (kcnt_r == 2'd2) && pend_v_r && !out_free)) begin
          if (keep) begin
            if (kcnt_r == 2'd2) begin
              if (pend_v_r) begin
                oval_nxt = 1'b1;
                opt_nxt  = pend_r;
                oemp_nxt = 1'b0;
                oovf_nxt = run_ovf_r;
                oeor_nxt = 1'b0;
              end
              pend_nxt   = sm;
              pend_v_nxt = 1'b1;
            end else begin
              kcnt_nxt = kcnt_r + 1'b1;
            end
            k0_nxt = k1_r;
            k1_nxt = pt_rdata;
          end
          prev_nxt = rd_y;
          if ((i_r + 1'b1) == n_r) begin
            state_nxt = ST_FIN;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_FLT_RD;
          end
        end
      end
      ST_FIN: begin
        // Last result of the run, or the empty marker.
        if (out_free) begin
          oval_nxt  = 1'b1;
          opt_nxt   = pend_v_r ? pend_r : '0;
          oemp_nxt  = !pend_v_r;
          oovf_nxt  = run_ovf_r;
          oeor_nxt  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      thr_r   <= GAP_RESET;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      oval_r <= oval_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    run_ovf_r <= run_ovf_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    rank_r    <= rank_nxt;
    key_r     <= key_nxt;
    prev_r    <= prev_nxt;
    kcnt_r    <= kcnt_nxt;
    k0_r      <= k0_nxt;
    k1_r      <= k1_nxt;
    pend_r    <= pend_nxt;
    pend_v_r  <= pend_v_nxt;
    opt_r     <= opt_nxt;
    oemp_r    <= oemp_nxt;
    oovf_r    <= oovf_nxt;
    oeor_r    <= oeor_nxt;
  end

  assign out_valid        = oval_r;
  assign out_x            = opt_r[3*CRD_W-1:2*CRD_W];
  assign out_y            = opt_r[2*CRD_W-1:CRD_W];
  assign out_z            = opt_r[CRD_W-1:0];
  assign out_empty_result = oemp_r;
  assign out_overflowed   = oovf_r;
  assign out_end_of_run   = oeor_r;

endmodule
